@@ design/cic_pkg.sv @@
// Crossing interlock controller: shared types, state codes and constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cic_pkg;

   localparam int DIRECTIONS_DEF = 4;
   localparam int REPORTED_DIRS  = 4;
   localparam int TIMER_W        = 12;
   localparam int SECS_W         = 8;
   localparam int CSR_INDEX_W    = 8;
   localparam int TENTHS         = 10;

   // direction state codes
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_REQUEST   = 3'd1;
   localparam logic [2:0] ST_CLEARANCE = 3'd2;
   localparam logic [2:0] ST_TIMEOUT   = 3'd3;
   localparam logic [2:0] ST_TIMER     = 3'd4;
   localparam logic [2:0] ST_OCCUPIED  = 3'd5;
   localparam logic [2:0] ST_CLEAR     = 3'd6;
   localparam logic [2:0] ST_LOCKOUT   = 3'd7;

   // signal aspects
   localparam logic [2:0] AS_RED    = 3'h4;
   localparam logic [2:0] AS_YELLOW = 3'h2;
   localparam logic [2:0] AS_GREEN  = 3'h1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_APPROACH_TIMEOUT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKOUT          = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIM_APPROACH     = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIM_TOTAL        = 8'd3;

   localparam logic [SECS_W-1:0] APPROACH_TIMEOUT_RST = 8'd5;
   localparam logic [SECS_W-1:0] LOCKOUT_RST          = 8'd5;

   typedef struct packed {
      logic [2:0]         st;
      logic [TIMER_W-1:0] timeout;
      logic [TIMER_W-1:0] sim_timer;
      logic               sim_en;
   } dir_ctx_type;

   typedef struct packed {
      logic [TIMER_W-1:0] approach_ticks;
      logic [TIMER_W-1:0] lockout_ticks;
      logic [TIMER_W-1:0] total_ticks;
      logic [TIMER_W-1:0] enter_level;
   } timing_type;

   typedef struct packed {
      logic [REPORTED_DIRS-1:0][2:0] main_aspect;
      logic [REPORTED_DIRS-1:0][2:0] second_aspect;
      logic                          lock_held;
      logic [REPORTED_DIRS-1:0]      lock_grant;
      logic [REPORTED_DIRS-1:0]      green_lamps;
   } result_type;

endpackage

@@ design/crossing_interlock_controller.sv @@
// Crossing interlock controller, top level: scan register, per-direction machines,
// lock chain and result register. Uses cic_pkg, cic_dir and cic_signals.
// rsp_valid rises once a req transfer has passed the scan register, then the result register.
// Throughput: one scan per cycle while rsp_stall is low; the direction chain is combinational.
// Reset (synchronous): all directions idle, timers zero, lock released, registers at defaults.
// csr_ready is always high.
`timescale 1ns / 1ps

module crossing_interlock_controller #(
   parameter int DIRECTIONS = cic_pkg::DIRECTIONS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_tick,
   input  logic [3:0]                       req_approach_main_occ,
   input  logic [1:0]                       req_approach_siding_occ,
   input  logic [1:0]                       req_turnout_rev,
   input  logic                             req_crossing_occ,
   input  logic [3:0]                       req_sim_start,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_main_aspect_0,
   output logic [2:0]                       rsp_main_aspect_1,
   output logic [2:0]                       rsp_main_aspect_2,
   output logic [2:0]                       rsp_main_aspect_3,
   output logic [2:0]                       rsp_second_aspect_0,
   output logic [2:0]                       rsp_second_aspect_1,
   output logic [2:0]                       rsp_second_aspect_2,
   output logic [2:0]                       rsp_second_aspect_3,
   output logic                             rsp_lock_held,
   output logic [3:0]                       rsp_lock_grant,
   output logic [3:0]                       rsp_green_lamps,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cic_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cic_pkg::SECS_W-1:0]       csr_data
);
   import cic_pkg::*;

   // configuration
   logic [SECS_W-1:0] approach_timeout_ff, lockout_ff, sim_approach_ff, sim_total_ff;
   logic [SECS_W-1:0] sim_appr_clamped;
   timing_type        timing;

   // scan register
   logic       in_valid_ff, in_valid_in;
   logic       in_tick_ff;
   logic [3:0] in_main_ff;
   logic [1:0] in_siding_ff;
   logic [1:0] in_turn_ff;
   logic       in_xocc_ff;
   logic [3:0] in_start_ff;
   logic       req_take, in_take, out_free;

   // direction state and lock
   dir_ctx_type         dir_ff [DIRECTIONS];
   dir_ctx_type         dir_cur [DIRECTIONS];
   dir_ctx_type         dir_in [DIRECTIONS];
   logic [DIRECTIONS-1:0] occ, start;
   logic [DIRECTIONS:0] lock_ff;
   logic [DIRECTIONS:0] lock_chain [DIRECTIONS+1];

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         approach_timeout_ff <= APPROACH_TIMEOUT_RST;
         lockout_ff <= LOCKOUT_RST;
         sim_approach_ff <= '0;
         sim_total_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_APPROACH_TIMEOUT: approach_timeout_ff <= csr_data;
            CSR_LOCKOUT:          lockout_ff <= csr_data;
            CSR_SIM_APPROACH:     sim_approach_ff <= csr_data;
            CSR_SIM_TOTAL:        sim_total_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign sim_appr_clamped = (sim_approach_ff > sim_total_ff) ? sim_total_ff : sim_approach_ff;

   always_comb begin
      timing.approach_ticks = TIMER_W'(TENTHS * approach_timeout_ff);
      timing.lockout_ticks  = TIMER_W'(TENTHS * lockout_ff);
      timing.total_ticks    = TIMER_W'(TENTHS * sim_total_ff);
      timing.enter_level    = TIMER_W'(TENTHS * (sim_total_ff - sim_appr_clamped));
   end

   // handshake: the scan register moves on whenever the result slot is free
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign in_take     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !in_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_tick_ff <= req_tick;
         in_main_ff <= req_approach_main_occ;
         in_siding_ff <= req_approach_siding_occ;
         in_turn_ff <= req_turnout_rev;
         in_xocc_ff <= req_crossing_occ;
         in_start_ff <= req_sim_start;
      end
   end

   genvar g;
   generate
      for (g = 0; g < DIRECTIONS; g++) begin : g_dir
         // sensor selection; directions without a sensor read unoccupied / main
         if ((g % 2 == 0) && (g / 2 < 2)) begin : g_frog
            assign occ[g] = in_turn_ff[g / 2] ? in_siding_ff[g / 2] : in_main_ff[g];
         end else if (g < 4) begin : g_plain
            assign occ[g] = in_main_ff[g];
         end else begin : g_nosensor
            assign occ[g] = 1'b0;
         end
         if (g < 4) begin : g_start
            assign start[g] = in_start_ff[g];
         end else begin : g_nostart
            assign start[g] = 1'b0;
         end

         always_comb begin
            dir_cur[g] = dir_ff[g];
            if (in_tick_ff) begin
               if (dir_ff[g].timeout != '0) dir_cur[g].timeout = dir_ff[g].timeout - 1'b1;
               if (dir_ff[g].sim_timer != '0)
                  dir_cur[g].sim_timer = dir_ff[g].sim_timer - 1'b1;
            end
            if (start[g] && dir_ff[g].st == ST_IDLE) dir_cur[g].sim_en = 1'b1;
         end

         cic_dir #(
            .DIRECTIONS (DIRECTIONS),
            .IDX        (g)
         ) u_dir (
            .cur      (dir_cur[g]),
            .occ      (occ[g]),
            .xocc     (in_xocc_ff),
            .timing   (timing),
            .lock_in  (lock_chain[g]),
            .nxt      (dir_in[g]),
            .lock_out (lock_chain[g+1])
         );

         always_ff @(posedge clock) begin
            if (reset) begin
               dir_ff[g] <= '{st: ST_IDLE, timeout: '0, sim_timer: '0, sim_en: 1'b0};
            end else if (in_take) begin
               dir_ff[g] <= dir_in[g];
            end
         end
      end
   endgenerate

   assign lock_chain[0] = lock_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff <= '0;
      end else if (in_take) begin
         lock_ff <= lock_chain[DIRECTIONS];
      end
   end

   cic_signals #(
      .DIRECTIONS (DIRECTIONS)
   ) u_signals (
      .lock_word   (lock_chain[DIRECTIONS]),
      .turnout_rev (in_turn_ff),
      .result      (result_in)
   );

   assign rsp_valid_in = in_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_main_aspect_0   = result_ff.main_aspect[0];
   assign rsp_main_aspect_1   = result_ff.main_aspect[1];
   assign rsp_main_aspect_2   = result_ff.main_aspect[2];
   assign rsp_main_aspect_3   = result_ff.main_aspect[3];
   assign rsp_second_aspect_0 = result_ff.second_aspect[0];
   assign rsp_second_aspect_1 = result_ff.second_aspect[1];
   assign rsp_second_aspect_2 = result_ff.second_aspect[2];
   assign rsp_second_aspect_3 = result_ff.second_aspect[3];
   assign rsp_lock_held       = result_ff.lock_held;
   assign rsp_lock_grant      = result_ff.lock_grant;
   assign rsp_green_lamps     = result_ff.green_lamps;

   // at most one direction holds the grant
   a_grant_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(lock_ff[DIRECTIONS-1:0]))
      else $error("more than one direction granted");

   // a grant is only held together with the crossing lock
   a_grant_locked: assert property (@(posedge clock) disable iff (reset)
      (lock_ff[DIRECTIONS-1:0] != '0) |-> lock_ff[DIRECTIONS])
      else $error("grant without lock flag");

   // every scan that leaves the scan register shows up as a result
   a_scan_delivered: assert property (@(posedge clock) disable iff (reset)
      in_take |=> rsp_valid_ff)
      else $error("scan transfer lost");

endmodule

@@ design/cic_dir.sv @@
// Crossing interlock controller: next-state logic of one approach direction.
// Takes the lock word from the lower directions and hands it on; uses cic_pkg.
`timescale 1ns / 1ps

module cic_dir #(
   parameter int DIRECTIONS = cic_pkg::DIRECTIONS_DEF,
   parameter int IDX        = 0
) (
   input  cic_pkg::dir_ctx_type  cur,
   input  logic                  occ,
   input  logic                  xocc,
   input  cic_pkg::timing_type   timing,
   input  logic [DIRECTIONS:0]   lock_in,
   output cic_pkg::dir_ctx_type  nxt,
   output logic [DIRECTIONS:0]   lock_out
);
   import cic_pkg::*;

   logic [DIRECTIONS:0] lock_mine;

   always_comb begin
      lock_mine = '0;
      lock_mine[DIRECTIONS] = 1'b1;
      lock_mine[IDX] = 1'b1;
   end

   always_comb begin
      nxt = cur;
      lock_out = lock_in;
      case (cur.st)
         ST_IDLE: begin
            if (cur.sim_en || occ) nxt.st = ST_REQUEST;
         end
         ST_REQUEST: begin
            if (!lock_in[DIRECTIONS] && !xocc) begin
               lock_out = lock_mine;
               nxt.st = ST_CLEARANCE;
            end
         end
         ST_CLEARANCE: begin
            if (cur.sim_en) begin
               nxt.sim_timer = timing.total_ticks;
               nxt.st = ST_TIMER;
            end else if (!occ) begin
               nxt.timeout = timing.approach_ticks;
               nxt.st = ST_TIMEOUT;
            end else if (xocc) begin
               nxt.st = ST_OCCUPIED;
            end
         end
         ST_TIMEOUT: begin
            if (cur.timeout == '0) nxt.st = ST_CLEAR;
            else if (occ) nxt.st = ST_CLEARANCE;
            else if (xocc) nxt.st = ST_OCCUPIED;
         end
         ST_TIMER: begin
            if (cur.sim_timer <= timing.enter_level) nxt.st = ST_OCCUPIED;
         end
         ST_OCCUPIED: begin
            // grants drop, crossing stays locked
            lock_out = '0;
            lock_out[DIRECTIONS] = 1'b1;
            if (!cur.sim_en && !xocc) nxt.st = ST_CLEAR;
            else if (cur.sim_en && cur.sim_timer == '0) nxt.st = ST_CLEAR;
         end
         ST_CLEAR: begin
            lock_out = '0;
            nxt.sim_en = 1'b0;
            nxt.timeout = timing.lockout_ticks;
            nxt.st = ST_LOCKOUT;
         end
         default: begin
            if (cur.timeout == '0) nxt.st = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/cic_signals.sv @@
// Crossing interlock controller: aspects, grant and green masks from the lock word.
// Uses cic_pkg.
`timescale 1ns / 1ps

module cic_signals #(
   parameter int DIRECTIONS = cic_pkg::DIRECTIONS_DEF
) (
   input  logic [DIRECTIONS:0]  lock_word,
   input  logic [1:0]           turnout_rev,
   output cic_pkg::result_type  result
);
   import cic_pkg::*;

   logic [REPORTED_DIRS-1:0] grant4;

   genvar g;
   generate
      for (g = 0; g < REPORTED_DIRS; g++) begin : g_grant
         if (g < DIRECTIONS) begin : g_have
            assign grant4[g] = lock_word[g];
         end else begin : g_none
            assign grant4[g] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      result = '0;
      for (int i = 0; i < REPORTED_DIRS; i++) begin
         result.main_aspect[i] = AS_RED;
         result.second_aspect[i] = AS_RED;
         if (grant4[i]) begin
            // odd directions follow the turnout of their even partner
            if (turnout_rev[i >> 1]) begin
               result.main_aspect[i] = AS_RED;
               result.second_aspect[i] = (i % 2 == 1) ? AS_YELLOW : AS_GREEN;
            end else begin
               result.main_aspect[i] = AS_GREEN;
            end
         end
         result.green_lamps[i] = (result.main_aspect[i] == AS_GREEN);
      end
      result.lock_grant = grant4;
      result.lock_held = lock_word[DIRECTIONS];
   end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for crossing_interlock_controller: scripted and random sensor scans,
// each response checked against an interlock model or a typed row's aspects; uses cic_pkg.
`timescale 1ns / 1ps

module tb;
   import cic_pkg::*;

   localparam int DIRS            = DIRECTIONS_DEF;
   localparam int LIMIT           = 200000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int SCRIPT_ROWS     = 20;
   localparam logic [7:0] LOCK_FLAG = 8'h80;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAST_END = CSR_SIM_TOTAL + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALL_ONES = '1;

   typedef struct packed {
      logic       tick;
      logic [3:0] main_occ;
      logic [1:0] siding_occ;
      logic [1:0] turnout;
      logic       xing_occ;
      logic [3:0] start;
   } scan_type;

   typedef struct packed {
      scan_type   scan;
      logic       typed;
      result_type ind;
   } script_row_type;

   localparam result_type ALL_RED = '{{4{AS_RED}}, {4{AS_RED}}, 1'b0, 4'h0, 4'h0};
   localparam result_type DIR0_CLEARED =
      '{{AS_RED, AS_RED, AS_RED, AS_GREEN}, {4{AS_RED}}, 1'b1, 4'h1, 4'h1};

   // tick, main, siding, turnout, crossing, sim start; typed rows carry their aspects
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{'{1'b0, 4'h0, 2'h0, 2'h0, 1'b0, 4'h0}, 1'b1, ALL_RED},
      '{'{1'b0, 4'h1, 2'h0, 2'h0, 1'b0, 4'h0}, 1'b1, ALL_RED},
      '{'{1'b0, 4'h1, 2'h0, 2'h0, 1'b0, 4'h0}, 1'b1, DIR0_CLEARED},
      '{'{1'b0, 4'h1, 2'h0, 2'h0, 1'b1, 4'h0}, 1'b0, '0},
      '{'{1'b1, 4'h0, 2'h0, 2'h0, 1'b1, 4'h0}, 1'b0, '0},
      '{'{1'b1, 4'h0, 2'h0, 2'h0, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b1, 4'h0, 2'h0, 2'h0, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b1, 4'h0, 2'h0, 2'h0, 1'b0, 4'hf}, 1'b0, '0},
      '{'{1'b0, 4'h0, 2'h1, 2'h3, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b0, 4'h0, 2'h1, 2'h3, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b0, 4'h0, 2'h1, 2'h3, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b0, 4'h0, 2'h1, 2'h3, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b0, 4'h0, 2'h0, 2'h3, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b0, 4'h0, 2'h0, 2'h3, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b1, 4'hf, 2'h3, 2'h3, 1'b1, 4'hf}, 1'b0, '0},
      '{'{1'b1, 4'h0, 2'h0, 2'h0, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b0, 4'h8, 2'h0, 2'h0, 1'b1, 4'h0}, 1'b0, '0},
      '{'{1'b1, 4'h8, 2'h0, 2'h0, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b1, 4'h8, 2'h2, 2'h1, 1'b0, 4'h0}, 1'b0, '0},
      '{'{1'b1, 4'h8, 2'h0, 2'h2, 1'b0, 4'h2}, 1'b0, '0}
   };

   // approach timeout, lockout, sim approach, sim total
   localparam logic [SECS_W-1:0] PHASE_TIMING [PHASES][4] = '{
      '{8'd0, 8'd0, 8'd0, 8'd0},
      '{8'd1, 8'd1, 8'd2, 8'd1},
      '{8'd2, 8'd1, 8'd1, 8'd3},
      '{8'd255, 8'd255, 8'd255, 8'd255},
      '{8'd0, 8'd2, 8'd3, 8'd2},
      '{8'd1, 8'd0, 8'd0, 8'd2}
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_tick = 1'b0;
   logic [3:0]             req_approach_main_occ = '0;
   logic [1:0]             req_approach_siding_occ = '0;
   logic [1:0]             req_turnout_rev = '0;
   logic                   req_crossing_occ = 1'b0;
   logic [3:0]             req_sim_start = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_main_aspect_0;
   logic [2:0]             rsp_main_aspect_1;
   logic [2:0]             rsp_main_aspect_2;
   logic [2:0]             rsp_main_aspect_3;
   logic [2:0]             rsp_second_aspect_0;
   logic [2:0]             rsp_second_aspect_1;
   logic [2:0]             rsp_second_aspect_2;
   logic [2:0]             rsp_second_aspect_3;
   logic                   rsp_lock_held;
   logic [3:0]             rsp_lock_grant;
   logic [3:0]             rsp_green_lamps;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SECS_W-1:0]      csr_data = '0;

   crossing_interlock_controller dut (.*);

   // interlock model state, at its reset values
   logic [2:0]         leg_state [DIRS] = '{default: ST_IDLE};
   logic [TIMER_W-1:0] leg_timeout [DIRS] = '{default: '0};
   logic [TIMER_W-1:0] train_timer [DIRS] = '{default: '0};
   logic               train_run [DIRS] = '{default: 1'b0};
   logic [7:0]         xing_lock = '0;
   logic [SECS_W-1:0]  approach_hold_secs = APPROACH_TIMEOUT_RST;
   logic [SECS_W-1:0]  lockout_hold_secs = LOCKOUT_RST;
   logic [SECS_W-1:0]  train_enter_secs = '0;
   logic [SECS_W-1:0]  train_clear_secs = '0;

   result_type indication_q [$];
   scan_type   drift = '0;
   int         req_gap_pct = 0;
   int         rsp_stall_pct = 0;
   bit         failed = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   function automatic result_type scan_interlock(scan_type s);
      result_type        ind;
      logic [SECS_W-1:0] enter_secs;
      logic              occ;
      logic              siding;
      logic [2:0]        m;
      logic [2:0]        sec;
      int                d;
      enter_secs = (train_enter_secs > train_clear_secs) ? train_clear_secs : train_enter_secs;
      for (d = 0; d < DIRS; d++) begin
         if (s.tick) begin
            if (leg_timeout[d] != 0) leg_timeout[d]--;
            if (train_timer[d] != 0) train_timer[d]--;
         end
         if (s.start[d] && leg_state[d] == ST_IDLE) train_run[d] = 1'b1;
      end
      for (d = 0; d < DIRS; d++) begin
         // even directions read their siding sensor while their turnout is reversed; odd ones read main
         siding = s.turnout[d/2];
         occ = (d % 2 == 0 && siding) ? s.siding_occ[d/2] : s.main_occ[d];
         case (leg_state[d])
            ST_IDLE: begin
               if (train_run[d] || occ) leg_state[d] = ST_REQUEST;
            end
            ST_REQUEST: begin
               if (!xing_lock[7] && !s.xing_occ) begin
                  xing_lock = LOCK_FLAG | (8'd1 << d);
                  leg_state[d] = ST_CLEARANCE;
               end
            end
            ST_CLEARANCE: begin
               if (train_run[d]) begin
                  train_timer[d] = TIMER_W'(TENTHS * train_clear_secs);
                  leg_state[d] = ST_TIMER;
               end else if (!occ) begin
                  leg_timeout[d] = TIMER_W'(TENTHS * approach_hold_secs);
                  leg_state[d] = ST_TIMEOUT;
               end else if (s.xing_occ) begin
                  leg_state[d] = ST_OCCUPIED;
               end
            end
            ST_TIMEOUT: begin
               if (leg_timeout[d] == 0) leg_state[d] = ST_CLEAR;
               else if (occ) leg_state[d] = ST_CLEARANCE;
               else if (s.xing_occ) leg_state[d] = ST_OCCUPIED;
            end
            ST_TIMER: begin
               if (int'(train_timer[d]) <=
                   TENTHS * (int'(train_clear_secs) - int'(enter_secs)))
                  leg_state[d] = ST_OCCUPIED;
            end
            ST_OCCUPIED: begin
               xing_lock = LOCK_FLAG;
               if ((!train_run[d] && !s.xing_occ) || (train_run[d] && train_timer[d] == 0))
                  leg_state[d] = ST_CLEAR;
            end
            ST_CLEAR: begin
               xing_lock = '0;
               train_run[d] = 1'b0;
               leg_timeout[d] = TIMER_W'(TENTHS * lockout_hold_secs);
               leg_state[d] = ST_LOCKOUT;
            end
            default: begin
               if (leg_timeout[d] == 0) leg_state[d] = ST_IDLE;
            end
         endcase
      end
      ind = '0;
      for (d = 0; d < REPORTED_DIRS; d++) begin
         m = AS_RED;
         sec = AS_RED;
         if (xing_lock[d]) begin
            ind.lock_grant[d] = 1'b1;
            if (!s.turnout[d/2]) m = AS_GREEN;
            else sec = (d % 2 == 1) ? AS_YELLOW : AS_GREEN;
         end
         ind.main_aspect[d] = m;
         ind.second_aspect[d] = sec;
         ind.green_lamps[d] = (m == AS_GREEN);
      end
      ind.lock_held = xing_lock[7];
      return ind;
   endfunction

   // mostly slow-moving occupancy so trains run through the whole cycle; some pure noise
   function automatic scan_type next_scan();
      logic [31:0] raw;
      scan_type    s;
      int          d;
      raw = $urandom;
      if ($urandom_range(0, 9) == 0) return raw[13:0];
      for (d = 0; d < 4; d++)
         if ($urandom_range(0, 7) == 0) drift.main_occ[d] = ~drift.main_occ[d];
      for (d = 0; d < 2; d++) begin
         if ($urandom_range(0, 7) == 0) drift.siding_occ[d] = ~drift.siding_occ[d];
         if ($urandom_range(0, 15) == 0) drift.turnout[d] = ~drift.turnout[d];
      end
      if ($urandom_range(0, 5) == 0) drift.xing_occ = ~drift.xing_occ;
      s = drift;
      s.tick = ($urandom_range(0, 3) != 0);
      for (d = 0; d < 4; d++) s.start[d] = ($urandom_range(0, 9) == 0);
      return s;
   endfunction

   task automatic send_scan(input scan_type s, input logic typed, input result_type typed_ind);
      result_type predicted;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick <= s.tick;
      req_approach_main_occ <= s.main_occ;
      req_approach_siding_occ <= s.siding_occ;
      req_turnout_rev <= s.turnout;
      req_crossing_occ <= s.xing_occ;
      req_sim_start <= s.start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = scan_interlock(s);
      indication_q.push_back(typed ? typed_ind : predicted);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [SECS_W-1:0] val,
                            input logic last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (last) csr_valid <= 1'b0;
      case (idx)
         CSR_APPROACH_TIMEOUT: approach_hold_secs = val;
         CSR_LOCKOUT:          lockout_hold_secs = val;
         CSR_SIM_APPROACH:     train_enter_secs = val;
         CSR_SIM_TOTAL:        train_clear_secs = val;
         default: ;
      endcase
   endtask

   task automatic settle();
      while (indication_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic note_field(input string what, input int unsigned due, input int unsigned got);
      if (due != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, due, got);
         failed = 1'b1;
      end
   endtask

   task automatic take_indication();
      result_type due;
      result_type got;
      int         d;
      got.main_aspect = {rsp_main_aspect_3, rsp_main_aspect_2, rsp_main_aspect_1,
                         rsp_main_aspect_0};
      got.second_aspect = {rsp_second_aspect_3, rsp_second_aspect_2, rsp_second_aspect_1,
                           rsp_second_aspect_0};
      got.lock_held = rsp_lock_held;
      got.lock_grant = rsp_lock_grant;
      got.green_lamps = rsp_green_lamps;
      if (indication_q.size() == 0) begin
         $display("%0t: unexpected rsp transfer, expected none actual %0h", $time, got);
         failed = 1'b1;
      end else begin
         due = indication_q.pop_front();
         for (d = 0; d < REPORTED_DIRS; d++) begin
            note_field($sformatf("main_aspect_%0d", d), due.main_aspect[d], got.main_aspect[d]);
            note_field($sformatf("second_aspect_%0d", d), due.second_aspect[d],
                       got.second_aspect[d]);
         end
         note_field("lock_held", due.lock_held, got.lock_held);
         note_field("lock_grant", due.lock_grant, got.lock_grant);
         note_field("green_lamps", due.green_lamps, got.green_lamps);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) take_indication();
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   initial begin
      int n;
      int p;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      req_gap_pct = 25;
      rsp_stall_pct = 75;
      for (n = 0; n < SCRIPT_ROWS; n++)
         send_scan(SCRIPT[n].scan, SCRIPT[n].typed, SCRIPT[n].ind);
      for (p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         settle();
         if (p == 0) begin
            // writes past the register file must leave the timing untouched
            write_csr(CSR_PAST_END, SECS_W'($urandom), 1'b0);
            write_csr(CSR_ALL_ONES, SECS_W'($urandom), 1'b0);
         end
         write_csr(CSR_APPROACH_TIMEOUT, PHASE_TIMING[p][0], 1'b0);
         write_csr(CSR_LOCKOUT, PHASE_TIMING[p][1], 1'b0);
         write_csr(CSR_SIM_APPROACH, PHASE_TIMING[p][2], 1'b0);
         write_csr(CSR_SIM_TOTAL, PHASE_TIMING[p][3], 1'b1);
         case (p / 2)
            0: begin
               req_gap_pct = 25;
               rsp_stall_pct = 75;
            end
            1: begin
               req_gap_pct = 75;
               rsp_stall_pct = 25;
            end
            default: begin
               req_gap_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         repeat (ITEMS_PER_PHASE) send_scan(next_scan(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      settle();
      if (!failed && indication_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
